@@ hw/rtl/stb_pkg.sv @@
// Shared types and constants for the soft timer bank.
package stb_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	localparam int CMD_W = 3;
	localparam int IDX_W = 4;
	localparam int TICK_W = 16;

	localparam logic [TICK_W-1:0] WINDOW_RESET = 16'd50;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_SET     = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_REARM   = 3'd3,
		CMD_STOP    = 3'd4,
		CMD_CHECK   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

@@ hw/rtl/stb_ctrl.sv @@
// Controller state machine: input handshake, execute step and result valid.
module stb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	output stb_pkg::dp_cmd_t   dp_cmd
);

	stb_pkg::state_t state_q;
	logic            out_valid_q;
	logic            out_free;

	// Result register can take a new item when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall  = (state_q != stb_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	// Decode commands to the datapath
	always_comb begin
		dp_cmd.capture = 1'b0;
		dp_cmd.execute = 1'b0;
		unique case (state_q)
			stb_pkg::ST_IDLE: begin
				dp_cmd.capture = in_valid;
			end
			stb_pkg::ST_EXEC: begin
				dp_cmd.execute = out_free;
			end
			default: begin
				dp_cmd.capture = 1'b0;
				dp_cmd.execute = 1'b0;
			end
		endcase
	end

	// Advance state and track the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				stb_pkg::ST_IDLE: begin
					if (in_valid) state_q <= stb_pkg::ST_EXEC;
				end
				stb_pkg::ST_EXEC: begin
					if (out_free) state_q <= stb_pkg::ST_IDLE;
				end
				default: begin
					state_q <= stb_pkg::ST_IDLE;
				end
			endcase
			if (dp_cmd.execute) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ hw/rtl/stb_dp.sv @@
// Datapath: tick counter, window flag, timer table and result register.
module stb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stb_pkg::dp_cmd_t              dp_cmd,
	input  logic                          cfg_we,
	input  logic [stb_pkg::TICK_W-1:0]    cfg_wdata,
	input  logic [stb_pkg::CMD_W-1:0]     cmd,
	input  logic [stb_pkg::IDX_W-1:0]     timer_index,
	input  logic [stb_pkg::TICK_W-1:0]    interval,
	input  logic                          start_flag,
	output logic                          expired,
	output logic                          running,
	output logic [stb_pkg::TICK_W-1:0]    tick_value
);

	// Captured input item
	logic [stb_pkg::CMD_W-1:0]  cmd_q;
	logic [stb_pkg::IDX_W-1:0]  idx_q;
	logic [stb_pkg::TICK_W-1:0] ivl_q;
	logic                       start_q;

	// Bank state
	logic [stb_pkg::TICK_W-1:0] wrap_window_q;
	logic [stb_pkg::TICK_W-1:0] tick_q;
	logic                       window_q;
	logic [stb_pkg::TICK_W-1:0] interval_q [stb_pkg::NUM_TIMERS];
	logic [stb_pkg::TICK_W-1:0] deadline_q [stb_pkg::NUM_TIMERS];
	logic                       wrapped_q  [stb_pkg::NUM_TIMERS];
	logic                       running_q  [stb_pkg::NUM_TIMERS];

	// Result register
	logic                       expired_q;
	logic                       running_out_q;
	logic [stb_pkg::TICK_W-1:0] tick_out_q;

	// Next-value logic
	logic [stb_pkg::TIDX_W-1:0] sel;
	logic                       idx_ok;
	logic [stb_pkg::TICK_W-1:0] tick_nxt;
	logic [stb_pkg::TICK_W-1:0] arm_ivl;
	logic [stb_pkg::TICK_W-1:0] arm_dl;
	logic                       arm_wrap;
	logic                       do_arm;
	logic                       run_nxt;
	logic                       wrap_nxt;
	logic                       exp_nxt;

	assign sel    = stb_pkg::TIDX_W'(idx_q);
	assign idx_ok = (32'(idx_q) < 32'(stb_pkg::NUM_TIMERS));

	assign tick_nxt = tick_q + 16'd1;
	assign arm_ivl  = (cmd_q == stb_pkg::CMD_SET) ? ivl_q : interval_q[sel];
	assign arm_dl   = tick_q + arm_ivl;
	assign arm_wrap = (arm_dl < tick_q);

	// Work out the addressed timer's next run state, wrap mark and check result
	always_comb begin
		do_arm   = 1'b0;
		run_nxt  = running_q[sel];
		wrap_nxt = wrapped_q[sel];
		exp_nxt  = 1'b0;
		case (cmd_q)
			stb_pkg::CMD_SET: begin
				do_arm  = 1'b1;
				run_nxt = start_q;
			end
			stb_pkg::CMD_RESTART: begin
				do_arm  = 1'b1;
				run_nxt = 1'b1;
			end
			stb_pkg::CMD_REARM: begin
				do_arm = 1'b1;
			end
			stb_pkg::CMD_STOP: begin
				run_nxt = 1'b0;
			end
			stb_pkg::CMD_CHECK: begin
				if (!wrapped_q[sel]) begin
					exp_nxt = running_q[sel] && (tick_q >= deadline_q[sel]);
				end else if (window_q) begin
					wrap_nxt = 1'b0;
				end
			end
			default: begin
				do_arm = 1'b0;
			end
		endcase
		if (do_arm) wrap_nxt = arm_wrap;
		if (!idx_ok) begin
			do_arm  = 1'b0;
			exp_nxt = 1'b0;
		end
	end

	// Capture the item and the window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_window_q <= stb_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			wrap_window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			cmd_q   <= cmd;
			idx_q   <= timer_index;
			ivl_q   <= interval;
			start_q <= start_flag;
		end
	end

	// Apply the command to the bank state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			window_q <= 1'b0;
			for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
				interval_q[i] <= '0;
				deadline_q[i] <= '0;
				wrapped_q[i]  <= 1'b0;
				running_q[i]  <= 1'b0;
			end
		end else if (dp_cmd.execute) begin
			if (cmd_q == stb_pkg::CMD_TICK) begin
				tick_q   <= tick_nxt;
				window_q <= (tick_nxt <= wrap_window_q);
			end else if (idx_ok) begin
				running_q[sel] <= run_nxt;
				wrapped_q[sel] <= wrap_nxt;
				if (do_arm) deadline_q[sel] <= arm_dl;
				if (cmd_q == stb_pkg::CMD_SET) interval_q[sel] <= ivl_q;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (dp_cmd.execute) begin
			expired_q <= exp_nxt;
			if (cmd_q == stb_pkg::CMD_TICK) begin
				running_out_q <= idx_ok && running_q[sel];
				tick_out_q    <= tick_nxt;
			end else begin
				running_out_q <= idx_ok && run_nxt;
				tick_out_q    <= tick_q;
			end
		end
	end

	assign expired    = expired_q;
	assign running    = running_out_q;
	assign tick_value = tick_out_q;

endmodule

@@ hw/rtl/soft_timer_bank.sv @@
// An accepted item is captured, then executed into the result register once it is free;
// in_stall stays high until that execute, so no new item is taken before the last is done.
// The result register frees the input side while a result waits to be taken.
// Reset: arst_n clears the tick counter, window flag and all timers (stopped);
// the window register resets to 50. No clearing pass is needed.
// Top level of the soft timer bank.
module soft_timer_bank (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [stb_pkg::TICK_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [stb_pkg::CMD_W-1:0]     cmd,
	input  logic [stb_pkg::IDX_W-1:0]     timer_index,
	input  logic [stb_pkg::TICK_W-1:0]    interval,
	input  logic                          start_flag,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          expired,
	output logic                          running,
	output logic [stb_pkg::TICK_W-1:0]    tick_value
);

	stb_pkg::dp_cmd_t dp_cmd;

	stb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	stb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.timer_index (timer_index),
		.interval    (interval),
		.start_flag  (start_flag),
		.expired     (expired),
		.running     (running),
		.tick_value  (tick_value)
	);

endmodule
